### hw/rtl/assert_macros.svh
// assertion macros used by the lock top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BKL_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bakery lock check failed");
`define BKL_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("bakery lock forbidden condition");
`else
`define BKL_ASSERT(name, clk, rstn, prop)
`define BKL_ASSERT_NEVER(name, clk, rstn, cond)
`endif

`endif

### hw/rtl/bkl_pkg.sv
// shared types and constants of the bakery ticket lock
package bkl_pkg;

  localparam int TID_W    = 3;   // requester id field width
  localparam int TICKET_W = 16;  // ticket field width

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_POLL    = 2'd1,
    ACT_RELEASE = 2'd2
  } bkl_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FIN
  } bkl_state_t;

  // token that walks down the cell chain
  typedef struct packed {
    logic             vld;
    logic [TID_W-1:0] who;
  } bkl_tok_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [TID_W-1:0] who;
  } bkl_wr_t;

endpackage

### hw/rtl/bkl_cell.sv
// one requester cell: holds flag and label, merges them into the passing sweep
module bkl_cell #(
  parameter int LABEL_BITS = 16,
  parameter int IDX_W      = 3,
  parameter int CELL_ID    = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bkl_pkg::bkl_tok_t     tok_i,
  input  logic [LABEL_BITS-1:0] max_i,
  input  logic                  minv_i,
  input  logic [LABEL_BITS-1:0] minl_i,
  input  logic [IDX_W-1:0]      mini_i,
  input  logic [LABEL_BITS-1:0] ownl_i,
  input  logic                  ownf_i,
  output bkl_pkg::bkl_tok_t     tok_o,
  output logic [LABEL_BITS-1:0] max_o,
  output logic                  minv_o,
  output logic [LABEL_BITS-1:0] minl_o,
  output logic [IDX_W-1:0]      mini_o,
  output logic [LABEL_BITS-1:0] ownl_o,
  output logic                  ownf_o,
  input  bkl_pkg::bkl_wr_t      wr_i,
  input  logic                  wr_flag_i,
  input  logic [LABEL_BITS-1:0] wr_label_i
);

  localparam int CW = (IDX_W > bkl_pkg::TID_W) ? IDX_W : bkl_pkg::TID_W;
  localparam logic [CW-1:0]    MY_CMP = CW'(CELL_ID);
  localparam logic [IDX_W-1:0] MY_ID  = IDX_W'(CELL_ID);

  logic                  flag_r;
  logic [LABEL_BITS-1:0] label_r;
  bkl_pkg::bkl_tok_t     tok_r;
  logic [LABEL_BITS-1:0] max_r, minl_r, ownl_r;
  logic                  minv_r, ownf_r;
  logic [IDX_W-1:0]      mini_r;

  logic is_me, wr_me, take_min;

  assign is_me    = (CW'(tok_i.who) == MY_CMP);
  assign wr_me    = wr_i.en && (CW'(wr_i.who) == MY_CMP);
  // ids arrive in rising order, so a tie on label keeps the earlier id
  assign take_min = !is_me && flag_r && (!minv_i || (label_r < minl_i));

  // stored requester state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r  <= 1'b0;
      label_r <= '0;
    end else if (wr_me) begin
      flag_r  <= wr_flag_i;
      label_r <= wr_label_i;
    end
  end

  // token, the id rides along with the valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_i;
    end
  end

  // sweep payload, held while no token passes
  always_ff @(posedge clk) begin
    if (tok_i.vld) begin
      max_r     <= (label_r > max_i) ? label_r : max_i;
      minv_r    <= take_min ? 1'b1 : minv_i;
      minl_r    <= take_min ? label_r : minl_i;
      mini_r    <= take_min ? MY_ID : mini_i;
      ownl_r    <= is_me ? label_r : ownl_i;
      ownf_r    <= is_me ? flag_r : ownf_i;
    end
  end

  assign tok_o  = tok_r;
  assign max_o  = max_r;
  assign minv_o = minv_r;
  assign minl_o = minl_r;
  assign mini_o = mini_r;
  assign ownl_o = ownl_r;
  assign ownf_o = ownf_r;

endmodule

### hw/rtl/bakery_ticket_lock.sv
// top level of the bakery ticket lock: controller and chain of requester cells
//
// usage
//   input beat: in_tuser carries the action (request, poll, release), in_tdata
//   the requester id. every input beat yields exactly one output beat with the
//   ticket now held, the may-enter verdict and the saturation flag.
//   each requester lives in its own cell. an accepted beat launches a token
//   that walks the chain one cell per cycle, collecting the largest label, the
//   smallest flagged (label, id) pair of the other requesters and the caller's
//   own entry. at the tail the controller settles the answer and, for a
//   request or release, writes the caller's cell back.
//   from accept an item passes the launch register, the cell chain of
//   NUM_REQUESTERS cells and the final state, and the output register then
//   raises out_tvalid; an id outside the populated range skips the sweep and
//   answers zeros from the final state. one item is in flight at a time, the
//   next beat is taken the cycle after the result is registered.
//   reset clears every flag and label to zero and empties the output register.
//   a stalled receiver holds the result in the output register; a finished
//   item waits in the final state and in_tready stays low until room frees up
module bakery_ticket_lock #(
  parameter int NUM_REQUESTERS = 8,
  parameter int LABEL_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [2:0] requester id, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [15:0] ticket, [16] may_enter, [17] ticket_overflow
);

  localparam int IDX_W = $clog2(NUM_REQUESTERS);
  localparam int CW    = (IDX_W > bkl_pkg::TID_W) ? IDX_W : bkl_pkg::TID_W;
  localparam int CMPW  = CW + 1;
  localparam logic [LABEL_BITS-1:0] LABEL_MAX = {LABEL_BITS{1'b1}};

  // controller state
  bkl_pkg::bkl_state_t           state_r, state_nxt;
  logic [1:0]                    act_r;
  logic [bkl_pkg::TID_W-1:0]     who_r;
  logic                          bad_r, bad_nxt;
  logic                          launch_r, launch_nxt;

  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bkl_pkg::TICKET_W-1:0]  out_ticket_r;
  logic                          out_may_r, out_ovf_r;

  // chain links, index k feeds cell k
  bkl_pkg::bkl_tok_t     ch_tok  [0:NUM_REQUESTERS];
  logic [LABEL_BITS-1:0] ch_max  [0:NUM_REQUESTERS];
  logic                  ch_minv [0:NUM_REQUESTERS];
  logic [LABEL_BITS-1:0] ch_minl [0:NUM_REQUESTERS];
  logic [IDX_W-1:0]      ch_mini [0:NUM_REQUESTERS];
  logic [LABEL_BITS-1:0] ch_ownl [0:NUM_REQUESTERS];
  logic                  ch_ownf [0:NUM_REQUESTERS];

  bkl_pkg::bkl_wr_t      wr;
  logic                  wr_flag;
  logic [LABEL_BITS-1:0] wr_label;

  logic                  in_fire, tid_ok, fin_go, tail_vld;
  logic                  sat, blocked, res_flag, res_ovf;
  logic [LABEL_BITS-1:0] new_label, res_label;

  assign in_tready = (state_r == bkl_pkg::ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign tid_ok    = CMPW'(in_tdata[bkl_pkg::TID_W-1:0]) < CMPW'(NUM_REQUESTERS);
  assign tail_vld  = ch_tok[NUM_REQUESTERS].vld;
  // result can be registered once the output slot is free or being drained
  assign fin_go    = (state_r == bkl_pkg::ST_FIN) && (!out_valid_r || out_tready);

  // head of the chain starts empty
  assign ch_tok[0]     = '{vld: launch_r, who: who_r};
  assign ch_max[0]     = '0;
  assign ch_minv[0]    = 1'b0;
  assign ch_minl[0]    = '0;
  assign ch_mini[0]    = '0;
  assign ch_ownl[0]    = '0;
  assign ch_ownf[0]    = 1'b0;

  for (genvar k = 0; k < NUM_REQUESTERS; k++) begin : g_cell
    bkl_cell #(
      .LABEL_BITS (LABEL_BITS),
      .IDX_W      (IDX_W),
      .CELL_ID    (k)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (ch_tok[k]),
      .max_i      (ch_max[k]),
      .minv_i     (ch_minv[k]),
      .minl_i     (ch_minl[k]),
      .mini_i     (ch_mini[k]),
      .ownl_i     (ch_ownl[k]),
      .ownf_i     (ch_ownf[k]),
      .tok_o      (ch_tok[k+1]),
      .max_o      (ch_max[k+1]),
      .minv_o     (ch_minv[k+1]),
      .minl_o     (ch_minl[k+1]),
      .mini_o     (ch_mini[k+1]),
      .ownl_o     (ch_ownl[k+1]),
      .ownf_o     (ch_ownf[k+1]),
      .wr_i       (wr),
      .wr_flag_i  (wr_flag),
      .wr_label_i (wr_label)
    );
  end

  // settle the answer from the tail of the chain
  always_comb begin
    sat       = (ch_max[NUM_REQUESTERS] == LABEL_MAX);
    new_label = sat ? LABEL_MAX : (ch_max[NUM_REQUESTERS] + LABEL_BITS'(1));
    res_label = ch_ownl[NUM_REQUESTERS];
    res_flag  = ch_ownf[NUM_REQUESTERS];
    res_ovf   = 1'b0;
    wr.en     = 1'b0;
    case (act_r)
      bkl_pkg::ACT_REQUEST: begin
        res_label = new_label;
        res_flag  = 1'b1;
        res_ovf   = sat;
        wr.en     = fin_go && !bad_r;
      end
      bkl_pkg::ACT_RELEASE: begin
        res_flag  = 1'b0;
        wr.en     = fin_go && !bad_r;
      end
      default: begin
        // poll and the spare code leave the state alone
        wr.en     = 1'b0;
      end
    endcase
    wr.who   = who_r;
    wr_flag  = res_flag;
    wr_label = res_label;
    // another flagged requester with a smaller (label, id) pair wins
    blocked  = ch_minv[NUM_REQUESTERS] &&
               ((ch_minl[NUM_REQUESTERS] < res_label) ||
                ((ch_minl[NUM_REQUESTERS] == res_label) &&
                 (CW'(ch_mini[NUM_REQUESTERS]) < CW'(who_r))));
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      bkl_pkg::ST_IDLE: begin
        if (in_fire) begin
          bad_nxt = !tid_ok;
          if (tid_ok) begin
            launch_nxt = 1'b1;
            state_nxt  = bkl_pkg::ST_SWEEP;
          end else begin
            state_nxt  = bkl_pkg::ST_FIN;
          end
        end
      end
      bkl_pkg::ST_SWEEP: begin
        if (tail_vld) begin
          state_nxt = bkl_pkg::ST_FIN;
        end
      end
      bkl_pkg::ST_FIN: begin
        if (fin_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = bkl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bkl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bkl_pkg::ST_IDLE;
      launch_r    <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // captured command of the item in flight
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r <= in_tuser;
      who_r <= in_tdata[bkl_pkg::TID_W-1:0];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (bad_r) begin
        out_ticket_r <= '0;
        out_may_r    <= 1'b0;
        out_ovf_r    <= 1'b0;
      end else begin
        out_ticket_r <= bkl_pkg::TICKET_W'(res_label);
        out_may_r    <= res_flag && !blocked;
        out_ovf_r    <= res_ovf;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_ovf_r, out_may_r, out_ticket_r};

  // checks
  `include "assert_macros.svh"

  `BKL_ASSERT(a_tail_only_in_sweep, clk, rst_n, tail_vld |-> (state_r == bkl_pkg::ST_SWEEP))
  `BKL_ASSERT(a_launch_starts_sweep, clk, rst_n, launch_r |-> (state_r == bkl_pkg::ST_SWEEP))
  `BKL_ASSERT(a_fin_loads_output, clk, rst_n, fin_go |=> out_valid_r)
  `BKL_ASSERT_NEVER(a_ovf_needs_top_ticket, clk, rst_n,
                    out_valid_r && out_ovf_r && (out_ticket_r != bkl_pkg::TICKET_W'(LABEL_MAX)))

endmodule

### dv/tb_top.sv
// self-checking stream testbench for the bakery ticket lock
module tb_top;

  localparam int          LOCKERS       = 8;
  localparam logic [15:0] LABEL_TOP     = 16'hFFFF;
  // action code 3 has no enum member, it answers like a poll
  localparam logic [1:0]  ACT_SPARE     = 2'd3;
  localparam int          TAIL_CYCLES   = LOCKERS + 3 + 10;
  localparam int          PRESSURE_AT   = 60;    // input beats before the long hold
  localparam int          PRESSURE_HOLD = 400;   // cycles the receiver holds off
  localparam int          MAX_PRINTS    = 50;

  typedef struct packed {
    logic [1:0]  act;
    logic [2:0]  who;
    logic [7:0]  gap_after;
  } lock_op_t;

  typedef struct packed {
    logic [15:0] ticket;
    logic        may_enter;
    logic        overflow;
  } answer_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;   // [2:0] requester id, rest zero
  logic [1:0]  in_tuser   = '0;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [15:0] ticket, [16] may_enter, [17] ticket_overflow

  lock_op_t    lock_ops[$];       // beats waiting to be offered
  answer_t     due_answers[$];    // answers owed by the lock, oldest first
  int unsigned beats_in    = 0;
  int unsigned idle_left   = 0;
  int unsigned mismatches  = 0;

  // shadow copy of the lock state
  logic        flag_of  [LOCKERS];
  logic [15:0] label_of [LOCKERS];

  // per-requester lifecycle used to build well-formed random traffic
  logic        gen_busy  [LOCKERS];
  int unsigned gen_polls [LOCKERS];

  bakery_ticket_lock DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    if (mismatches < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // applies one action to the shadow state and returns the answer it owes
  function automatic answer_t serve_ticket_action(logic [1:0] act, logic [2:0] who);
    answer_t     ans;
    logic [15:0] top;
    ans = '0;
    if (act == bkl_pkg::ACT_REQUEST) begin
      top = '0;
      for (int j = 0; j < LOCKERS; j++)
        if (label_of[j] > top) top = label_of[j];
      flag_of[who] = 1'b1;
      // labels never wrap, the ceiling sticks and is reported
      if (top == LABEL_TOP) begin
        label_of[who] = LABEL_TOP;
        ans.overflow  = 1'b1;
      end else begin
        label_of[who] = top + 16'd1;
      end
    end else if (act == bkl_pkg::ACT_RELEASE) begin
      flag_of[who] = 1'b0;
    end
    ans.ticket    = label_of[who];
    ans.may_enter = flag_of[who];
    // any other flagged requester with a smaller (label, id) pair blocks entry
    for (int j = 0; j < LOCKERS; j++)
      if (j != who && flag_of[j] &&
          (label_of[j] < label_of[who] || (label_of[j] == label_of[who] && j < who)))
        ans.may_enter = 1'b0;
    return ans;
  endfunction

  function automatic logic [7:0] pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 8'd0;
    if (roll < 95) return 8'($urandom_range(1, 3));
    return 8'($urandom_range(10, 40));
  endfunction

  task automatic queue_op(input logic [1:0] act, input logic [2:0] who,
                          input logic [7:0] gap);
    lock_op_t op;
    op.act       = act;
    op.who       = who;
    op.gap_after = gap;
    lock_ops.push_back(op);
  endtask

  // mostly request / poll / release lifecycles, some loose noise beats
  task automatic queue_random_ops(input int count);
    logic [1:0]  act;
    logic [2:0]  who;
    int unsigned roll;
    logic        calm;
    for (int k = 0; k < count; k++) begin
      calm = ((k / 50) % 5) == 4;
      who  = 3'($urandom_range(0, LOCKERS - 1));
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
        if (!gen_busy[who]) begin
          act            = bkl_pkg::ACT_REQUEST;
          gen_busy[who]  = 1'b1;
          gen_polls[who] = $urandom_range(0, 4);
        end else if (gen_polls[who] != 0) begin
          act = bkl_pkg::ACT_POLL;
          gen_polls[who]--;
        end else begin
          act           = bkl_pkg::ACT_RELEASE;
          gen_busy[who] = 1'b0;
        end
      end else begin
        act = 2'($urandom_range(0, 3));
      end
      queue_op(act, who, calm ? 8'd0 : pick_gap());
    end
  endtask

  // checked at the falling edge so the test never races the clocked blocks
  task automatic wait_drained();
    while (lock_ops.size() != 0 || in_tvalid || idle_left != 0 || due_answers.size() != 0)
      @(negedge clk);
  endtask

  // driver: offers queued beats, predicts each one at acceptance
  always @(posedge clk) begin : in_side
    lock_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
      idle_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        due_answers.push_back(serve_ticket_action(in_tuser, in_tdata[2:0]));
        beats_in <= beats_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          in_tvalid <= 1'b0;
        end else if (lock_ops.size() != 0) begin
          op = lock_ops.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {5'b0, op.who};
          in_tuser  <= op.act;
          idle_left <= op.gap_after;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, one long hold to back up the lock
  always @(posedge clk) begin : rx_side
    int unsigned stall_left;
    int unsigned calm_left;
    logic        hold_done;
    int unsigned roll;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      calm_left  = 0;
      hold_done  = 1'b0;
    end else if (!hold_done && beats_in >= PRESSURE_AT) begin
      hold_done  = 1'b1;
      stall_left = PRESSURE_HOLD;
      out_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm_left != 0) begin
      calm_left--;
      out_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 79) begin
        out_tready <= 1'b1;
      end else if (roll < 80) begin
        calm_left = $urandom_range(40, 120);
        out_tready <= 1'b1;
      end else if (roll < 97) begin
        stall_left = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        stall_left = $urandom_range(10, 40);
        out_tready <= 1'b0;
      end
    end
  end

  // monitor: every accepted result against the oldest owed answer
  always @(posedge clk) begin : out_check
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_answers.size() == 0) begin
        flag_error($sformatf("result beat with nothing outstanding, tdata %h", out_tdata));
      end else begin
        want = due_answers.pop_front();
        if (out_tdata[15:0] != want.ticket)
          flag_error($sformatf("ticket %0d, want %0d", out_tdata[15:0], want.ticket));
        if (out_tdata[16] != want.may_enter)
          flag_error($sformatf("may_enter %b, want %b", out_tdata[16], want.may_enter));
        if (out_tdata[17] != want.overflow)
          flag_error($sformatf("ticket_overflow %b, want %b", out_tdata[17], want.overflow));
      end
    end
  end

  initial begin
    for (int j = 0; j < LOCKERS; j++) begin
      flag_of[j]   = 1'b0;
      label_of[j]  = '0;
      gen_busy[j]  = 1'b0;
      gen_polls[j] = 0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle polls, ordering by label, re-request, spare code, releases
    queue_op(bkl_pkg::ACT_POLL,    3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd3, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd7, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd7, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd1, pick_gap());
    queue_op(ACT_SPARE,            3'd7, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd7, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd7, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd0, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd2, pick_gap());
    queue_op(ACT_SPARE,            3'd2, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd2, pick_gap());
    wait_drained();

    // random traffic below the label ceiling, the long receiver hold lands here
    queue_random_ops(850);
    wait_drained();

    // everyone released, then a fresh round of competing requests
    for (int j = 0; j < LOCKERS; j++)
      queue_op(bkl_pkg::ACT_RELEASE, 3'(j), pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd2, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd2, pick_gap());
    queue_op(bkl_pkg::ACT_REQUEST, 3'd2, pick_gap());
    queue_op(ACT_SPARE,            3'd5, pick_gap());
    queue_op(bkl_pkg::ACT_RELEASE, 3'd2, pick_gap());
    queue_op(bkl_pkg::ACT_POLL,    3'd5, pick_gap());
    for (int j = 0; j < LOCKERS; j++)
      gen_busy[j] = 1'b0;
    queue_random_ops(850);
    wait_drained();

    // let any stray result surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
